[rtl/ordered_ready_queue_defines.svh]
// assertion macros for the ordered ready queue
`ifndef ORDERED_READY_QUEUE_DEFINES_SVH
`define ORDERED_READY_QUEUE_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication, checked out of reset
`define ORQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ordered_ready_queue assertion failed");
// next-cycle implication, checked out of reset
`define ORQ_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ordered_ready_queue assertion failed");
`else
`define ORQ_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define ORQ_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

[rtl/orq_pkg.sv]
// types, codes and compare function of the ordered ready queue
package orq_pkg;

    typedef struct packed {
        logic [15:0] id;
        logic [7:0]  pri;
        logic [15:0] tm;
    } t_entry;

    typedef enum logic [2:0] {
        ACT_ENQ  = 3'd0,
        ACT_DEQ  = 3'd1,
        ACT_PEEK = 3'd2,
        ACT_REM  = 3'd3,
        ACT_FIND = 3'd4,
        ACT_UPD  = 3'd5,
        ACT_CLR  = 3'd6
    } t_action;

    localparam logic [1:0] MODE_FIFO = 2'd0;
    localparam logic [1:0] MODE_SRT  = 2'd1;
    localparam logic [1:0] MODE_PRI  = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_INS_RD,
        ST_INS_WR,
        ST_DEL_RD,
        ST_DEL_WR
    } t_state;

    // new entry must stand before the held one
    function automatic logic goes_before(logic [1:0] mode, t_entry nw, t_entry old);
        logic r;
        r = 1'b0;
        case (mode)
            MODE_SRT: r = (nw.tm != old.tm) ? (nw.tm < old.tm) : (nw.id < old.id);
            MODE_PRI: r = (nw.pri != old.pri) ? (nw.pri < old.pri) : (nw.id < old.id);
            default:  r = 1'b0;
        endcase
        return r;
    endfunction

endpackage

[rtl/orq_ram.sv]
// generic simple dual-port ram with registered read
module orq_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[rtl/ordered_ready_queue.sv]
// top level of the ordered ready queue: sequencer around the entry ram
//
// channel   direction  ports                                   handshake
// command   in         i_action i_job_id i_job_priority        start & !busy
//                      i_remaining_time
// result    out        o_hit o_out_id o_out_priority o_out_time o_done, one cycle
//                      o_occupancy o_full_drop
// config    in         i_queue_mode                            i_queue_mode_we
//
// entries sit in ram in service order; every ram step is a read state that
// sets the address and a check or write state that sees the registered data
// enqueue scans for its slot in the sorted modes, then shifts entries from it up
// dequeue/remove scan for the entry, then shift the later entries down
// peek/find/update scan until the first match or the end of the queue
// clear, drop, empty and unused-action cases finish straight from idle
// result strobe o_done comes the cycle busy falls; receiver cannot stall
// synchronous active-low reset empties the queue and sets arrival order
module ordered_ready_queue
    import orq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_action,
    input  logic [15:0] i_job_id,
    input  logic [7:0]  i_job_priority,
    input  logic [15:0] i_remaining_time,
    input  logic        i_queue_mode_we,
    input  logic [1:0]  i_queue_mode,
    output logic        o_done,
    output logic        o_hit,
    output logic [15:0] o_out_id,
    output logic [7:0]  o_out_priority,
    output logic [15:0] o_out_time,
    output logic [4:0]  o_occupancy,
    output logic        o_full_drop
);
`include "ordered_ready_queue_defines.svh"

    localparam int IW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CW-1:0] FULL = CW'(QUEUE_DEPTH);

    // control state
    t_state        r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [1:0]    r_mode;
    logic          r_done, n_done;
    // item payload and scan pointers
    t_action       r_act, n_act;
    t_entry        r_new, n_new;
    logic [CW-1:0] r_idx, n_idx;
    logic [CW-1:0] r_pos, n_pos;
    // result
    logic          r_hit, n_hit;
    logic          r_drop, n_drop;
    t_entry        r_res, n_res;

    // ram port
    logic          ram_we;
    logic [IW-1:0] ram_waddr, ram_raddr;
    t_entry        ram_wdata, ram_rdata;
    logic [CW-1:0] idx_inc, idx_dec;
    logic          w_match;

    orq_ram #(.WIDTH($bits(t_entry)), .DEPTH(QUEUE_DEPTH)) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    assign idx_inc = r_idx + 1'b1;
    assign idx_dec = r_idx - 1'b1;
    // dequeue and peek take slot 0, the id lookups take the first equal id
    assign w_match = (r_act == ACT_DEQ) || (r_act == ACT_PEEK) || (ram_rdata.id == r_new.id);

    // next state and datapath
    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_done  = 1'b0;
        n_act   = r_act;
        n_new   = r_new;
        n_idx   = r_idx;
        n_pos   = r_pos;
        n_hit   = r_hit;
        n_drop  = r_drop;
        n_res   = r_res;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_act  = t_action'(i_action);
                    n_new  = '{id: i_job_id, pri: i_job_priority, tm: i_remaining_time};
                    n_hit  = 1'b0;
                    n_drop = 1'b0;
                    n_res  = '0;
                    n_idx  = '0;
                    case (i_action)
                        ACT_ENQ: begin
                            if (r_count == FULL) begin
                                n_drop = 1'b1;
                                n_done = 1'b1;
                            end else if ((r_mode == MODE_SRT || r_mode == MODE_PRI)
                                         && r_count != '0) begin
                                n_state = ST_SCAN_RD;
                            end else begin
                                // arrival order or empty queue: append at the tail
                                n_pos   = r_count;
                                n_idx   = r_count;
                                n_state = ST_INS_RD;
                            end
                        end
                        ACT_DEQ, ACT_PEEK, ACT_REM, ACT_FIND, ACT_UPD: begin
                            if (r_count == '0) begin
                                n_done = 1'b1;
                            end else begin
                                n_state = ST_SCAN_RD;
                            end
                        end
                        ACT_CLR: begin
                            n_count = '0;
                            n_done  = 1'b1;
                        end
                        default: begin
                            n_done = 1'b1;
                        end
                    endcase
                end
            end
            ST_SCAN_RD: begin
                n_state = ST_SCAN_CHK;
            end
            ST_SCAN_CHK: begin
                if (r_act == ACT_ENQ) begin
                    if (goes_before(r_mode, r_new, ram_rdata)) begin
                        n_pos   = r_idx;
                        n_idx   = r_count;
                        n_state = ST_INS_RD;
                    end else if (idx_inc == r_count) begin
                        n_pos   = r_count;
                        n_idx   = r_count;
                        n_state = ST_INS_RD;
                    end else begin
                        n_idx   = idx_inc;
                        n_state = ST_SCAN_RD;
                    end
                end else if (w_match) begin
                    n_hit = 1'b1;
                    n_res = ram_rdata;
                    if (r_act == ACT_UPD) begin
                        n_res.tm = r_new.tm;
                    end
                    if (r_act == ACT_DEQ || r_act == ACT_REM) begin
                        n_idx   = idx_inc;
                        n_state = ST_DEL_RD;
                    end else begin
                        n_done  = 1'b1;
                        n_state = ST_IDLE;
                    end
                end else if (idx_inc == r_count) begin
                    n_done  = 1'b1;
                    n_state = ST_IDLE;
                end else begin
                    n_idx   = idx_inc;
                    n_state = ST_SCAN_RD;
                end
            end
            ST_INS_RD: begin
                if (r_idx == r_pos) begin
                    n_count = r_count + 1'b1;
                    n_done  = 1'b1;
                    n_state = ST_IDLE;
                end else begin
                    n_state = ST_INS_WR;
                end
            end
            ST_INS_WR: begin
                n_idx   = idx_dec;
                n_state = ST_INS_RD;
            end
            ST_DEL_RD: begin
                if (r_idx == r_count) begin
                    n_count = r_count - 1'b1;
                    n_done  = 1'b1;
                    n_state = ST_IDLE;
                end else begin
                    n_state = ST_DEL_WR;
                end
            end
            ST_DEL_WR: begin
                n_idx   = idx_inc;
                n_state = ST_DEL_RD;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // ram addressing: reads lead writes by one step, so no entry is read and
    // written in flight at once
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_idx[IW-1:0];
        ram_wdata = ram_rdata;
        ram_raddr = r_idx[IW-1:0];
        unique case (r_state)
            ST_SCAN_CHK: begin
                if (r_act == ACT_UPD && w_match) begin
                    ram_we    = 1'b1;
                    ram_wdata = '{id: ram_rdata.id, pri: ram_rdata.pri, tm: r_new.tm};
                end
            end
            ST_INS_RD: begin
                ram_raddr = idx_dec[IW-1:0];
                if (r_idx == r_pos) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_pos[IW-1:0];
                    ram_wdata = r_new;
                end
            end
            ST_INS_WR: begin
                ram_we = 1'b1;
            end
            ST_DEL_WR: begin
                ram_we    = 1'b1;
                ram_waddr = idx_dec[IW-1:0];
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_mode  <= MODE_FIFO;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_done  <= n_done;
            if (i_queue_mode_we) begin
                r_mode <= i_queue_mode;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_act  <= n_act;
        r_new  <= n_new;
        r_idx  <= n_idx;
        r_pos  <= n_pos;
        r_hit  <= n_hit;
        r_drop <= n_drop;
        r_res  <= n_res;
    end

    assign busy           = (r_state != ST_IDLE);
    assign o_done         = r_done;
    assign o_hit          = r_hit;
    assign o_out_id       = r_res.id;
    assign o_out_priority = r_res.pri;
    assign o_out_time     = r_res.tm;
    assign o_occupancy    = 5'(r_count);
    assign o_full_drop    = r_drop;

    `ORQ_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= FULL)
    `ORQ_ASSERT_IMP(a_done_idle, i_clk, i_rst_n, o_done, r_state == ST_IDLE)
    `ORQ_ASSERT_IMP(a_drop_no_hit, i_clk, i_rst_n, o_done && o_full_drop, !o_hit)
    `ORQ_ASSERT_NXT(a_start_moves, i_clk, i_rst_n, start && !busy, busy || o_done)
endmodule
